// ----- rtl/core/kocr_pkg.sv -----
`default_nettype none

package kocr_pkg;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    // Fixed field widths
    localparam int REQ_KEY_BITS = 32;
    localparam int INDEX_BITS   = 4;
    localparam int AGE_BITS     = 5;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef enum logic
    {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } mode_t;

    typedef logic [AGE_BITS-1:0] age_t;

endpackage

`default_nettype wire

// ----- rtl/core/kocr_if.sv -----
`default_nettype none

// Request channel: one beat is one lookup or insert.
interface kocr_req_if;
    logic                                  valid;
    logic                                  ready;
    kocr_pkg::mode_t                       mode;
    logic [kocr_pkg::REQ_KEY_BITS-1:0]     key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

// Response channel: one beat per request.
interface kocr_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic [kocr_pkg::INDEX_BITS-1:0]       entry_index;
    logic                                  was_occupied;

    modport source (output valid, output hit, output entry_index, output was_occupied,
                    input ready);
    modport sink   (input valid, input hit, input entry_index, input was_occupied,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kocr_argmax.sv -----
`default_nettype none

// First-maximum search as a balanced compare tree; ties go to the lower index.
module kocr_argmax #(
    parameter int N  = kocr_pkg::ENTRIES_DEF,
    parameter int MW = 1
) (
    input  wire logic [MW-1:0]          metric [N],
    output logic      [$clog2(N)-1:0]   best_idx,
    output logic      [MW-1:0]          best_metric
);

    localparam int IW  = $clog2(N);
    localparam int PAD = 1 << IW;

    logic [MW-1:0] lvl_m [IW+1][PAD];
    logic [IW-1:0] lvl_i [IW+1][PAD];

    always_comb
    begin
        for (int l = 0; l <= IW; l++)
        begin
            for (int j = 0; j < PAD; j++)
            begin
                lvl_m[l][j] = '0;
                lvl_i[l][j] = '0;
            end
        end

        // padding leaves carry metric zero and never beat a real entry
        for (int j = 0; j < PAD; j++)
        begin
            lvl_i[0][j] = IW'(j);
            if (j < N)
            begin
                lvl_m[0][j] = metric[j];
            end
        end

        for (int l = 0; l < IW; l++)
        begin
            for (int j = 0; j < PAD / 2; j++)
            begin
                if (j < (PAD >> (l + 1)))
                begin
                    if (lvl_m[l][2*j+1] > lvl_m[l][2*j])
                    begin
                        lvl_m[l+1][j] = lvl_m[l][2*j+1];
                        lvl_i[l+1][j] = lvl_i[l][2*j+1];
                    end
                    else
                    begin
                        lvl_m[l+1][j] = lvl_m[l][2*j];
                        lvl_i[l+1][j] = lvl_i[l][2*j];
                    end
                end
            end
        end
    end

    assign best_idx    = lvl_i[IW][0];
    assign best_metric = lvl_m[IW][0];

endmodule

`default_nettype wire

// ----- rtl/core/keyed_object_cache_replacement.sv -----
`default_nettype none

// Fully associative key directory with FIFO replacement. A lookup beat
// (mode = lookup) compares the key against all ENTRIES slots at once and
// returns hit with the lowest matching slot, or hit = 0 and index 0 on a
// miss; it leaves the directory unchanged. An insert beat stores the key in
// a victim slot with age 0 and ages every other valid slot by one
// (saturating at 31); the victim is the first empty slot, else the first
// slot of greatest nonzero age, else slot 0. No duplicate check is made on
// insert. entry_index carries the low 4 bits of the slot number. Only the
// low KEY_BITS bits of the key take part (zero-extended when KEY_BITS is
// above 32). Timing: a beat is taken into an input register, resolved
// there by the parallel compare bank and a log2(ENTRIES)-deep priority
// tree while the response register is free or draining, and presented
// from the response register; one beat per cycle is sustained as long
// as the response side keeps up. The directory state is written on the
// same edge that loads the response, so each beat sees all earlier inserts.
module keyed_object_cache_replacement #(
    parameter int ENTRIES  = kocr_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kocr_pkg::KEY_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kocr_req_if.sink    req,
    kocr_rsp_if.source  rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int VW = kocr_pkg::AGE_BITS + 1;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    kocr_pkg::mode_t       s1_mode_reg;
    logic [KEY_BITS-1:0]   s1_key_reg;

    // Response register
    logic                            out_valid_reg;
    logic                            out_hit_reg;
    logic [kocr_pkg::INDEX_BITS-1:0] out_index_reg;
    logic                            out_occ_reg;

    // Directory
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    kocr_pkg::age_t        age_reg  [ENTRIES];
    kocr_pkg::age_t        age_next [ENTRIES];
    logic [KEY_BITS-1:0]   key_reg  [ENTRIES];
    logic [KEY_BITS-1:0]   key_next [ENTRIES];

    logic advance;
    logic is_insert;

    // stage 1 moves on when the response register is free or being drained
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign is_insert = (s1_mode_reg == kocr_pkg::MODE_INSERT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_mode_reg <= req.mode;
            s1_key_reg  <= KEY_BITS'(req.key);
        end
    end

    // ---------------------------------------------------------------
    // Match bank: one compare per slot, first match wins
    // ---------------------------------------------------------------
    logic [0:0]     hit_metric [ENTRIES];
    logic [IW-1:0]  hit_idx;
    logic [0:0]     hit_any;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_metric[i] = valid_reg[i] && (key_reg[i] == s1_key_reg);
        end
    end

    kocr_argmax #(
        .N  (ENTRIES),
        .MW (1)
    ) u_hit_search (
        .metric      (hit_metric),
        .best_idx    (hit_idx),
        .best_metric (hit_any)
    );

    // ---------------------------------------------------------------
    // Victim search. Metric {empty, age}: any empty slot outranks every
    // valid one, and empty slots all carry age 0 so the first one wins.
    // With all slots valid the first greatest age wins; if every age is
    // zero the tree falls back to slot 0 by its left-on-tie rule.
    // ---------------------------------------------------------------
    logic [VW-1:0]  vic_metric [ENTRIES];
    logic [IW-1:0]  vic_idx;
    logic [VW-1:0]  vic_best;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            vic_metric[i] = valid_reg[i] ? {1'b0, age_reg[i]} : {1'b1, kocr_pkg::age_t'(0)};
        end
    end

    kocr_argmax #(
        .N  (ENTRIES),
        .MW (VW)
    ) u_victim_search (
        .metric      (vic_metric),
        .best_idx    (vic_idx),
        .best_metric (vic_best)
    );

    // ---------------------------------------------------------------
    // Directory update on insert
    // ---------------------------------------------------------------
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            key_next[i] = key_reg[i];
        end

        if (advance && is_insert)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IW'(i) == vic_idx)
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                    key_next[i]   = s1_key_reg;
                end
                else if (valid_reg[i] && (age_reg[i] != kocr_pkg::AGE_MAX))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // key storage is never read while its slot is invalid: no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i] <= key_next[i];
        end
    end

    // ---------------------------------------------------------------
    // Response register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (is_insert)
            begin
                out_hit_reg   <= 1'b0;
                out_index_reg <= kocr_pkg::INDEX_BITS'(vic_idx);
                out_occ_reg   <= ~vic_best[VW-1];
            end
            else
            begin
                // a miss leaves hit_idx at slot 0
                out_hit_reg   <= hit_any[0];
                out_index_reg <= kocr_pkg::INDEX_BITS'(hit_idx);
                out_occ_reg   <= 1'b0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.entry_index  = out_index_reg;
    assign rsp.was_occupied = out_occ_reg;

endmodule

`default_nettype wire

// ----- rtl/core/kocr_checker.sv -----
`default_nettype none

module kocr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            rsp_hit,
    input wire logic [kocr_pkg::INDEX_BITS-1:0] rsp_entry_index,
    input wire logic                            rsp_was_occupied
);

    logic req_beat;
    assign req_beat = req_valid && req_ready;

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
            && $stable(rsp_entry_index) && $stable(rsp_was_occupied))
        else $error("response changed while stalled");

    // a fresh response comes from a request beat that passed through the input register
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_beat, 2))
        else $error("response without matching request");

    // response stalled and a new beat taken: both stages are full, so the
    // request side then only moves when the response side does
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready && req_beat
            |=> rsp_valid && (req_ready == rsp_ready))
        else $error("request taken with pipeline full");

endmodule

bind keyed_object_cache_replacement kocr_checker u_kocr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_hit          (rsp.hit),
    .rsp_entry_index  (rsp.entry_index),
    .rsp_was_occupied (rsp.was_occupied)
);

`default_nettype wire

// ----- tb/sv/keyed_object_cache_replacement_tb.sv -----
`default_nettype none

module keyed_object_cache_replacement_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = kocr_pkg::ENTRIES_DEF;
    localparam int KEY_BITS     = kocr_pkg::KEY_BITS_DEF;
    localparam int RANDOM_BEATS = 1400;
    localparam int HOLD_CYCLES  = 120;      // long response-side hold-off
    localparam int DRAIN_CYCLES = 16;       // input and response registers, plenty of margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HISTORY_MAX  = 64;

    typedef logic [kocr_pkg::REQ_KEY_BITS-1:0] key_t;

    // Expected response beat, one per accepted request.
    typedef struct packed {
        logic                            hit;
        logic [kocr_pkg::INDEX_BITS-1:0] entry_index;
        logic                            was_occupied;
    } rsp_beat_t;

    logic clk;
    logic rst_n;

    kocr_req_if req_ch ();
    kocr_rsp_if rsp_ch ();

    keyed_object_cache_replacement #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow directory: our own copy of the slot state.
    // ------------------------------------------------------------------
    logic           dir_valid [ENTRIES];
    key_t           dir_key   [ENTRIES];
    kocr_pkg::age_t dir_age   [ENTRIES];

    rsp_beat_t   expected_rsp [$];      // responses still owed by the block
    key_t        key_history  [$];      // recently inserted keys, evicted or not
    int unsigned errors;
    int unsigned cycle_count;

    // Hold-off handshake with the receiver: bump hold_asks to request one.
    int unsigned hold_asks;

    // ------------------------------------------------------------------
    // Clock and cycle counter
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
    end

    // Watchdog: the run never legitimately gets close to this.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                 $time, cycle_count, expected_rsp.size());
        $display("** keyed_object_cache_replacement: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directory predictor. Lookups search for the lowest valid matching
    // slot and leave ages alone. Inserts pick the first empty slot, else
    // the first slot with the largest nonzero age, else slot 0, and age
    // every other valid slot by one with saturation.
    // ------------------------------------------------------------------
    function automatic rsp_beat_t resolve_request(input kocr_pkg::mode_t m, input key_t k);
        rsp_beat_t      r;
        int             i;
        int             victim;
        kocr_pkg::age_t best_age;
        r = '0;
        if (m == kocr_pkg::MODE_LOOKUP)
        begin
            for (i = ENTRIES - 1; i >= 0; i--)
            begin
                // scan downward so the lowest match is the one that sticks
                if (dir_valid[i] && dir_key[i] == k)
                begin
                    r.hit         = 1'b1;
                    r.entry_index = i[kocr_pkg::INDEX_BITS-1:0];
                end
            end
        end
        else
        begin
            victim = -1;
            for (i = 0; i < ENTRIES; i++)
            begin
                if (victim < 0 && !dir_valid[i])
                    victim = i;
            end
            if (victim < 0)
            begin
                victim   = 0;
                best_age = '0;
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (dir_age[i] > best_age)
                    begin
                        best_age = dir_age[i];
                        victim   = i;
                    end
                end
            end
            r.was_occupied = dir_valid[victim];
            r.entry_index  = victim[kocr_pkg::INDEX_BITS-1:0];
            for (i = 0; i < ENTRIES; i++)
            begin
                if (i != victim && dir_valid[i] && dir_age[i] != kocr_pkg::AGE_MAX)
                    dir_age[i] = dir_age[i] + 1'b1;
            end
            dir_valid[victim] = 1'b1;
            dir_key[victim]   = k;
            dir_age[victim]   = '0;
            key_history.push_back(k);
            if (key_history.size() > HISTORY_MAX)
                void'(key_history.pop_front());
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Everything is driven with NBAs right after a rising
    // edge; valid is left high after a beat so back-to-back calls keep it
    // asserted without a low/high pair in the same step.
    // ------------------------------------------------------------------
    task automatic send_request(input kocr_pkg::mode_t m, input key_t k);
        req_ch.valid <= 1'b1;
        req_ch.mode  <= m;
        req_ch.key   <= k;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        // accepted at this edge
        expected_rsp.push_back(resolve_request(m, k));
    endtask

    task automatic idle_cycles(input int unsigned n);
        req_ch.valid <= 1'b0;
        req_ch.mode  <= kocr_pkg::mode_t'($urandom_range(0, 1));
        req_ch.key   <= $urandom;       // junk payload while not valid
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: stall pattern is picked at random among no
    // stalls, light and heavy random stalls, and a fixed 1-in-3 stall.
    // A hold-off request overrides the pattern and holds ready low.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_seen;
        int unsigned hold_left;
        int unsigned phase_cnt;
        int unsigned stall_mode;
        hold_seen  = 0;
        hold_left  = 0;
        phase_cnt  = 0;
        stall_mode = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_cnt % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            phase_cnt = phase_cnt + 1;
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
                    default: rsp_ch.ready <= (phase_cnt % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Response checker: every accepted beat against the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_beat_t exp_beat;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected response beat: expected none, %s",
                             $time, "actual below");
                    $display("%0t:   actual hit=%b idx=%0d occ=%b", $time,
                             rsp_ch.hit, rsp_ch.entry_index, rsp_ch.was_occupied);
                end
                else
                begin
                    exp_beat = expected_rsp.pop_front();
                    if (rsp_ch.hit !== exp_beat.hit)
                    begin
                        errors = errors + 1;
                        $display("%0t: hit mismatch: expected %b, actual %b",
                                 $time, exp_beat.hit, rsp_ch.hit);
                    end
                    if (rsp_ch.entry_index !== exp_beat.entry_index)
                    begin
                        errors = errors + 1;
                        $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                                 $time, exp_beat.entry_index, rsp_ch.entry_index);
                    end
                    if (rsp_ch.was_occupied !== exp_beat.was_occupied)
                    begin
                        errors = errors + 1;
                        $display("%0t: was_occupied mismatch: expected %b, actual %b",
                                 $time, exp_beat.was_occupied, rsp_ch.was_occupied);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lookups into an empty directory must all miss with index 0.
    task automatic test_empty_lookup();
        send_request(kocr_pkg::MODE_LOOKUP, '0);
        send_request(kocr_pkg::MODE_LOOKUP, '1);
    endtask

    // Fill all slots in order: each insert takes the next empty slot.
    task automatic test_fill_directory();
        int i;
        send_request(kocr_pkg::MODE_INSERT, 32'h0000_0000);
        send_request(kocr_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_request(kocr_pkg::MODE_INSERT, 32'hAAAA_AAAA);
        send_request(kocr_pkg::MODE_INSERT, 32'h5555_5555);
        send_request(kocr_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(kocr_pkg::MODE_INSERT, 32'h0000_0001);
        for (i = 6; i < ENTRIES; i++)
            send_request(kocr_pkg::MODE_INSERT, $urandom);
    endtask

    // Hits at both ends of the key range, plus a miss on a full directory.
    task automatic test_lookup_hits();
        idle_cycles(3);
        send_request(kocr_pkg::MODE_LOOKUP, 32'h0000_0000);
        send_request(kocr_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);
        send_request(kocr_pkg::MODE_LOOKUP, 32'h1234_5678);
    endtask

    // Duplicate insert of a resident key lands in the oldest slot; lookup
    // then reports the lower of the two copies. The evicted key misses.
    task automatic test_duplicate_insert();
        send_request(kocr_pkg::MODE_INSERT, 32'h8000_0000);   // evicts slot 0
        send_request(kocr_pkg::MODE_LOOKUP, 32'h8000_0000);   // now hits slot 0
        send_request(kocr_pkg::MODE_INSERT, 32'h0000_0000);   // evicted key back in slot 1
        send_request(kocr_pkg::MODE_LOOKUP, 32'h0000_0000);
        send_request(kocr_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);   // slot 1 was overwritten
    endtask

    // Receiver holds off for a long stretch while requests keep coming:
    // the pipeline fills and the request side must stall without loss.
    task automatic test_output_stall();
        int   i;
        key_t k;
        wait_for_drain();
        hold_asks = hold_asks + 1;
        for (i = 0; i < 30; i++)
        begin
            k = (i % 2 == 0) ? dir_key[$urandom_range(0, ENTRIES - 1)] : key_t'($urandom);
            send_request(kocr_pkg::mode_t'($urandom_range(0, 1)), k);
        end
        // sender pauses until every owed response has arrived
        wait_for_drain();
    endtask

    // Random traffic in bursts. Most lookups target resident or recently
    // evicted keys so hits and misses both stay common.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned     sent;
        int unsigned     burst_left;
        int unsigned     gap;
        int unsigned     pick;
        int              slot;
        kocr_pkg::mode_t m;
        key_t            k;
        sent       = 0;
        burst_left = 0;
        while (sent < count)
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                    idle_cycles(gap);
            end
            if (sent % 350 == 349)
            begin
                wait_for_drain();
                if ($urandom_range(0, 1) == 0)
                    hold_asks = hold_asks + 1;
            end

            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, ENTRIES - 1);
            if (pick < 40)
            begin
                m = kocr_pkg::MODE_LOOKUP;
                k = dir_valid[slot] ? dir_key[slot] : key_t'($urandom);
            end
            else if (pick < 50)
            begin
                m = kocr_pkg::MODE_LOOKUP;
                k = key_history[$urandom_range(0, key_history.size() - 1)];
            end
            else if (pick < 60)
            begin
                m = kocr_pkg::MODE_LOOKUP;
                k = $urandom;
            end
            else if (pick < 63)
            begin
                m = kocr_pkg::mode_t'($urandom_range(0, 1));
                k = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            else if (pick < 87)
            begin
                m = kocr_pkg::MODE_INSERT;
                k = $urandom;
            end
            else
            begin
                // duplicate insert of a key that may still be resident
                m = kocr_pkg::MODE_INSERT;
                k = key_history[$urandom_range(0, key_history.size() - 1)];
            end

            send_request(m, k);
            sent       = sent + 1;
            burst_left = burst_left - 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        errors    = 0;
        hold_asks = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_key[i]   = '0;
            dir_age[i]   = '0;
        end
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= kocr_pkg::MODE_LOOKUP;
        req_ch.key   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_fill_directory();
        test_lookup_hits();
        test_duplicate_insert();
        test_output_stall();
        test_random_traffic(RANDOM_BEATS);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            errors = errors + 1;
            $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
        end

        if (errors == 0)
            $display("** keyed_object_cache_replacement: PASSED **");
        else
            $display("** keyed_object_cache_replacement: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
